// File: design/afk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afk_pkg: shared types, constants and tables for the arm position unit
// Field widths, register codes, micro-op format and sequence, sine table.
// ----------------------------------------------------------------------------
package afk_pkg;

    // field widths
    localparam int ANG_W     = 9;
    localparam int IDX_W     = 3;
    localparam int POS_W     = 24;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int SINE_BITS_DEF = 16;

    // configuration register codes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LINK = 2'd2;

    localparam logic [15:0] BASE_HEIGHT_RST = 16'd768;
    localparam logic [15:0] FIRST_LINK_RST  = 16'd512;
    localparam logic [15:0] SECOND_LINK_RST = 16'd768;

    localparam logic MODE_MOVE  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [IDX_W-1:0] SERVO1 = 3'd1;
    localparam logic [IDX_W-1:0] SERVO2 = 3'd2;
    localparam logic [IDX_W-1:0] SERVO3 = 3'd3;
    localparam logic [IDX_W-1:0] SERVO4 = 3'd4;
    localparam logic [IDX_W-1:0] SERVO5 = 3'd5;

    // trig scratch file
    localparam int NUM_TREGS = 19;
    localparam int T_AW      = $clog2(NUM_TREGS);

    localparam logic [T_AW-1:0] T_S0   = 5'd0;
    localparam logic [T_AW-1:0] T_S1   = 5'd1;
    localparam logic [T_AW-1:0] T_S2   = 5'd2;
    localparam logic [T_AW-1:0] T_S3   = 5'd3;
    localparam logic [T_AW-1:0] T_C0   = 5'd4;
    localparam logic [T_AW-1:0] T_C1   = 5'd5;
    localparam logic [T_AW-1:0] T_C2   = 5'd6;
    localparam logic [T_AW-1:0] T_C3   = 5'd7;
    localparam logic [T_AW-1:0] T_C0C1 = 5'd8;
    localparam logic [T_AW-1:0] T_S0C1 = 5'd9;
    localparam logic [T_AW-1:0] T_C0S1 = 5'd10;
    localparam logic [T_AW-1:0] T_S0S1 = 5'd11;
    localparam logic [T_AW-1:0] T_P1   = 5'd12;
    localparam logic [T_AW-1:0] T_P2   = 5'd13;
    localparam logic [T_AW-1:0] T_P3   = 5'd14;
    localparam logic [T_AW-1:0] T_Q1   = 5'd15;
    localparam logic [T_AW-1:0] T_Q2   = 5'd16;
    localparam logic [T_AW-1:0] T_Q3   = 5'd17;

    // accumulators
    localparam logic [1:0] ACC_X = 2'd0;
    localparam logic [1:0] ACC_Y = 2'd1;
    localparam logic [1:0] ACC_Z = 2'd2;

    // length select
    localparam logic [1:0] LEN_H  = 2'd0;
    localparam logic [1:0] LEN_L1 = 2'd1;
    localparam logic [1:0] LEN_L2 = 2'd2;

    // micro-op kinds
    localparam logic [1:0] K_RND    = 2'd0;  // t[dst] = +-round(a*b)
    localparam logic [1:0] K_RNDADD = 2'd1;  // t[dst] = prev +- round(a*b)
    localparam logic [1:0] K_ACC    = 2'd2;  // acc[dst] += +-(a*b), exact
    localparam logic [1:0] K_NONE   = 2'd3;

    localparam logic POS = 1'b0;
    localparam logic NEG = 1'b1;

    localparam int NUM_UOPS    = 28;
    localparam int UOP_IW      = 5;
    localparam int TRIG_STEPS  = 8;
    localparam int FLUSH_STEPS = 2;

    typedef struct packed {
        logic [1:0]      kind;
        logic            sgn;
        logic            a_len;
        logic [1:0]      len_sel;
        logic [T_AW-1:0] a_idx;
        logic            b_one;
        logic [T_AW-1:0] b_idx;
        logic [T_AW-1:0] dst;
        logic [IDX_W-1:0] level;
    } t_uop;

    typedef struct packed {
        logic              accept;
        logic              trig_en;
        logic [2:0]        trig_step;
        logic              issue;
        logic [UOP_IW-1:0] uop_idx;
        logic              out_load;
    } t_cmd;

    function automatic t_uop f_mk(input logic [1:0] kind, input logic sgn,
                                  input logic a_len, input logic [1:0] len_sel,
                                  input logic [T_AW-1:0] a_idx, input logic b_one,
                                  input logic [T_AW-1:0] b_idx,
                                  input logic [T_AW-1:0] dst,
                                  input logic [IDX_W-1:0] level);
        t_uop u;
        u.kind    = kind;
        u.sgn     = sgn;
        u.a_len   = a_len;
        u.len_sel = len_sel;
        u.a_idx   = a_idx;
        u.b_one   = b_one;
        u.b_idx   = b_idx;
        u.dst     = dst;
        u.level   = level;
        return u;
    endfunction

    // Query sequence. A consumer of a t entry trails its producer by three or more
    // slots; each K_RNDADD directly follows the K_RND whose value it adds to.
    function automatic t_uop f_uop(input logic [UOP_IW-1:0] n);
        t_uop u;
        unique case (n)
            5'd0:  u = f_mk(K_RND, POS, 1'b0, LEN_H, T_C0, 1'b0, T_C1, T_C0C1, SERVO2);
            5'd1:  u = f_mk(K_RND, POS, 1'b0, LEN_H, T_S0, 1'b0, T_C1, T_S0C1, SERVO2);
            5'd2:  u = f_mk(K_RND, POS, 1'b0, LEN_H, T_C0, 1'b0, T_S1, T_C0S1, SERVO2);
            5'd3:  u = f_mk(K_RND, POS, 1'b0, LEN_H, T_S0, 1'b0, T_S1, T_S0S1, SERVO2);
            5'd4:  u = f_mk(K_RND, POS, 1'b0, LEN_H, T_S1, 1'b0, T_C2, T_P3, SERVO2);
            5'd5:  u = f_mk(K_ACC, POS, 1'b1, LEN_H, T_S0, 1'b1, T_S0,
                            T_AW'(ACC_Z), SERVO2);
            5'd6:  u = f_mk(K_ACC, POS, 1'b1, LEN_L1, T_S0, 1'b0, T_S1,
                            T_AW'(ACC_Z), SERVO3);
            5'd7:  u = f_mk(K_ACC, POS, 1'b1, LEN_L1, T_S0, 1'b0, T_C0C1,
                            T_AW'(ACC_X), SERVO3);
            5'd8:  u = f_mk(K_ACC, POS, 1'b1, LEN_L1, T_S0, 1'b0, T_S0C1,
                            T_AW'(ACC_Y), SERVO3);
            5'd9:  u = f_mk(K_ACC, POS, 1'b1, LEN_H, T_S0, 1'b0, T_C0S1,
                            T_AW'(ACC_X), SERVO4);
            5'd10: u = f_mk(K_ACC, POS, 1'b1, LEN_H, T_S0, 1'b0, T_S0S1,
                            T_AW'(ACC_Y), SERVO4);
            5'd11: u = f_mk(K_ACC, NEG, 1'b1, LEN_H, T_S0, 1'b0, T_C1,
                            T_AW'(ACC_Z), SERVO4);
            5'd12: u = f_mk(K_RND, POS, 1'b0, LEN_H, T_C0C1, 1'b0, T_C2, T_P1, SERVO2);
            5'd13: u = f_mk(K_RNDADD, POS, 1'b0, LEN_H, T_S0, 1'b0, T_S2, T_P1, SERVO2);
            5'd14: u = f_mk(K_RND, POS, 1'b0, LEN_H, T_S0C1, 1'b0, T_C2, T_P2, SERVO2);
            5'd15: u = f_mk(K_RNDADD, NEG, 1'b0, LEN_H, T_C0, 1'b0, T_S2, T_P2, SERVO2);
            5'd16: u = f_mk(K_RND, POS, 1'b0, LEN_H, T_C0S1, 1'b0, T_S3, T_Q1, SERVO2);
            5'd17: u = f_mk(K_RND, POS, 1'b0, LEN_H, T_S0S1, 1'b0, T_S3, T_Q2, SERVO2);
            5'd18: u = f_mk(K_RND, POS, 1'b0, LEN_H, T_C1, 1'b0, T_S3, T_Q3, SERVO2);
            5'd19: u = f_mk(K_RND, POS, 1'b0, LEN_H, T_C3, 1'b0, T_P1, T_P1, SERVO2);
            5'd20: u = f_mk(K_RND, POS, 1'b0, LEN_H, T_C3, 1'b0, T_P2, T_P2, SERVO2);
            5'd21: u = f_mk(K_RND, POS, 1'b0, LEN_H, T_P3, 1'b0, T_C3, T_P3, SERVO2);
            5'd22: u = f_mk(K_ACC, NEG, 1'b1, LEN_L2, T_S0, 1'b0, T_Q1,
                            T_AW'(ACC_X), SERVO5);
            5'd23: u = f_mk(K_ACC, NEG, 1'b1, LEN_L2, T_S0, 1'b0, T_Q2,
                            T_AW'(ACC_Y), SERVO5);
            5'd24: u = f_mk(K_ACC, NEG, 1'b1, LEN_L2, T_S0, 1'b0, T_Q3,
                            T_AW'(ACC_Z), SERVO5);
            5'd25: u = f_mk(K_ACC, POS, 1'b1, LEN_L2, T_S0, 1'b0, T_P1,
                            T_AW'(ACC_X), SERVO5);
            5'd26: u = f_mk(K_ACC, POS, 1'b1, LEN_L2, T_S0, 1'b0, T_P2,
                            T_AW'(ACC_Y), SERVO5);
            5'd27: u = f_mk(K_ACC, POS, 1'b1, LEN_L2, T_S0, 1'b0, T_P3,
                            T_AW'(ACC_Z), SERVO5);
            default: u = f_mk(K_NONE, POS, 1'b0, LEN_H, T_S0, 1'b0, T_S0, T_S0, SERVO5);
        endcase
        return u;
    endfunction

    // quarter-wave sine table, sin(k deg) for k = 0..90
    localparam int SINE_EW = 25;
    typedef logic [SINE_EW-1:0] t_sine_entry;
    typedef t_sine_entry t_sine_tab [0:90];

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint          Q30_ONE = 64'sd1073741824;

    // Q30 Taylor series to x^17, round half up per step, then rounded to sb bits
    function automatic t_sine_tab f_build_sine(input int sb);
        t_sine_tab       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned half;
        longint          s;
        for (int k = 0; k <= 90; k++) begin
            half = 64'd1 << 29;
            x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
            x2   = (x * x + half) >> 30;
            term = x;
            s    = longint'(x);
            term = ((term * x2 + half) >> 30) / 64'd6;   s = s - longint'(term);
            term = ((term * x2 + half) >> 30) / 64'd20;  s = s + longint'(term);
            term = ((term * x2 + half) >> 30) / 64'd42;  s = s - longint'(term);
            term = ((term * x2 + half) >> 30) / 64'd72;  s = s + longint'(term);
            term = ((term * x2 + half) >> 30) / 64'd110; s = s - longint'(term);
            term = ((term * x2 + half) >> 30) / 64'd156; s = s + longint'(term);
            term = ((term * x2 + half) >> 30) / 64'd210; s = s - longint'(term);
            term = ((term * x2 + half) >> 30) / 64'd272; s = s + longint'(term);
            if (s < 0) begin
                s = 0;
            end
            if (s > Q30_ONE) begin
                s = Q30_ONE;
            end
            tab[k] = SINE_EW'((s + (64'sd1 <<< (29 - sb))) >>> (30 - sb));
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

// File: design/arm_forward_kinematics_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arm_forward_kinematics_unit: four-joint arm angle store and position query
// Move items store a joint angle; query items return servo x, y, z.
// ----------------------------------------------------------------------------
// Sequence: a move transfer goes straight to result hand-off; a query transfer
//   runs 8 trig lookups, 28 micro-ops on one shared multiplier, a pipe flush
//   and an output load before its result is valid.
// The unit takes one item at a time: a new transfer is taken only once the
//   previous item's result has been loaded. A stalled result holds the unit
//   once the next item is done.
// Reset: synchronous, active low; angles go to 0 deg, link registers to defaults.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_unit #(
    parameter int SINE_BITS = afk_pkg::SINE_BITS_DEF   // sine table fraction bits
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // item input channel
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic                             i_mode,
    input  wire logic [afk_pkg::IDX_W-1:0]        i_joint_index,
    input  wire logic signed [afk_pkg::ANG_W-1:0] i_angle_deg,
    // result channel
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic signed [afk_pkg::POS_W-1:0]      o_pos_x,
    output logic signed [afk_pkg::POS_W-1:0]      o_pos_y,
    output logic signed [afk_pkg::POS_W-1:0]      o_pos_z,
    output logic signed [afk_pkg::ANG_W-1:0]      o_echo_angle,
    // config write port
    input  wire logic                             i_cfg_we,
    input  wire logic [afk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [afk_pkg::LEN_W-1:0]        i_cfg_data
);

    // Commands from the sequencer: accept an item, run trig lookups,
    // issue micro-ops, load the result register.
    afk_pkg::t_cmd w_cmd;

    // The sequencer takes a new transfer only when idle. The result sits in
    // an output register, so the next item can be taken while it waits.
    afk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_mode      (i_mode),
        .i_out_stall (i_stall),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    // Datapath: joint angles, link registers, sine lookup, one multiplier,
    // exact x/y/z accumulators and the output rounding/saturation.
    afk_datapath #(
        .SINE_BITS (SINE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_mode        (i_mode),
        .i_joint_index (i_joint_index),
        .i_angle_deg   (i_angle_deg),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_echo_angle  (o_echo_angle)
    );

endmodule
`default_nettype wire

// File: design/afk_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afk_ram: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module afk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
`default_nettype wire

// File: design/afk_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afk_ctrl: sequencer for the arm position unit
// Handshakes, trig lookup steps, micro-op issue and result hand-off.
// ----------------------------------------------------------------------------
module afk_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_mode,
    input  wire logic          i_out_stall,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output afk_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TRIG  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam int CW = afk_pkg::UOP_IW;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          w_accept;
    logic          w_out_free;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_state = (i_mode == afk_pkg::MODE_QUERY) ? S_TRIG : S_DONE;
                end
            end
            S_TRIG: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(afk_pkg::TRIG_STEPS - 1)) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                end
            end
            S_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(afk_pkg::NUM_UOPS - 1)) begin
                    n_state = S_FLUSH;
                    n_cnt   = '0;
                end
            end
            S_FLUSH: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(afk_pkg::FLUSH_STEPS - 1)) begin
                    n_state = S_DONE;
                    n_cnt   = '0;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd.accept    = w_accept;
        o_cmd.trig_en   = (r_state == S_TRIG);
        o_cmd.trig_step = r_cnt[2:0];
        o_cmd.issue     = (r_state == S_RUN);
        o_cmd.uop_idx   = r_cnt;
        o_cmd.out_load  = (r_state == S_DONE) && w_out_free;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_query_starts_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_mode == afk_pkg::MODE_QUERY) |=> (r_state == S_TRIG))
        else $error("query transfer did not start trig lookups");

    a_move_goes_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_mode == afk_pkg::MODE_MOVE) |=> (r_state == S_DONE))
        else $error("move transfer did not go to result hand-off");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result valid rose outside hand-off");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt < CW'(afk_pkg::NUM_UOPS)))
        else $error("micro-op counter out of range");

    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (r_state == S_IDLE && r_out_valid))
        else $error("hand-off did not present result");

endmodule
`default_nettype wire

// File: design/afk_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afk_datapath: joint store, trig lookup, shared multiplier, accumulators
// Three-stage micro-op pipe: read, multiply, write back / accumulate.
// ----------------------------------------------------------------------------
module afk_datapath #(
    parameter int SINE_BITS = afk_pkg::SINE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire afk_pkg::t_cmd                 i_cmd,
    input  wire logic                          i_mode,
    input  wire logic [afk_pkg::IDX_W-1:0]     i_joint_index,
    input  wire logic signed [afk_pkg::ANG_W-1:0] i_angle_deg,
    input  wire logic                          i_cfg_we,
    input  wire logic [afk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [afk_pkg::LEN_W-1:0]     i_cfg_data,
    output logic signed [afk_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [afk_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [afk_pkg::POS_W-1:0]   o_pos_z,
    output logic signed [afk_pkg::ANG_W-1:0]   o_echo_angle
);

    localparam int TW  = SINE_BITS + 3;                       // trig word
    localparam int OW  = (TW > afk_pkg::LEN_W + 1) ? TW : afk_pkg::LEN_W + 1;
    localparam int PW  = 2 * OW;
    localparam int AW  = PW + 3;
    localparam int PWN = afk_pkg::POS_W;
    localparam int AWG = afk_pkg::ANG_W;
    localparam int TA  = afk_pkg::T_AW;

    localparam afk_pkg::t_sine_tab SINE_TAB = afk_pkg::f_build_sine(SINE_BITS);

    localparam logic signed [AW-1:0] SAT_HI = (AW'(1) <<< (PWN - 1)) - AW'(1);
    localparam logic signed [AW-1:0] SAT_LO = -(AW'(1) <<< (PWN - 1));

    // config and joint state
    logic [afk_pkg::LEN_W-1:0] r_base_height;
    logic [afk_pkg::LEN_W-1:0] r_first_link;
    logic [afk_pkg::LEN_W-1:0] r_second_link;
    logic signed [AWG-1:0]     r_joint [4];

    logic                          r_mode;
    logic [afk_pkg::IDX_W-1:0]     r_idx;
    logic signed [AWG-1:0]         r_echo;
    logic [1:0]                    w_jsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_height <= afk_pkg::BASE_HEIGHT_RST;
            r_first_link  <= afk_pkg::FIRST_LINK_RST;
            r_second_link <= afk_pkg::SECOND_LINK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                afk_pkg::CFG_BASE_HEIGHT: r_base_height <= i_cfg_data;
                afk_pkg::CFG_FIRST_LINK:  r_first_link  <= i_cfg_data;
                afk_pkg::CFG_SECOND_LINK: r_second_link <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_jsel = 2'(i_joint_index - afk_pkg::SERVO1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) begin
                r_joint[j] <= '0;
            end
        end else if (i_cmd.accept && i_mode == afk_pkg::MODE_MOVE &&
                     i_joint_index >= afk_pkg::SERVO1 &&
                     i_joint_index <= afk_pkg::SERVO4) begin
            r_joint[w_jsel] <= i_angle_deg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_idx  <= i_joint_index;
            r_echo <= (i_mode == afk_pkg::MODE_MOVE && i_joint_index >= afk_pkg::SERVO1 &&
                       i_joint_index <= afk_pkg::SERVO5) ? i_angle_deg : '0;
        end
    end

    // trig lookup: sin(a) or cos(a) = sin(a + 90), folded into the first quadrant
    logic [1:0]            w_tj;
    logic                  w_tcos;
    logic signed [10:0]    w_tsum;
    logic [8:0]            w_tdeg;
    logic [6:0]            w_tk;
    logic                  w_tneg;
    logic [TW-1:0]         w_tmag;
    logic [TW-1:0]         w_tval;

    assign w_tj   = i_cmd.trig_step[2:1];
    assign w_tcos = i_cmd.trig_step[0];

    always_comb begin
        w_tsum = 11'(r_joint[w_tj]) + (w_tcos ? 11'sd90 : 11'sd0);
        w_tdeg = (w_tsum < 0) ? 9'(w_tsum + 11'sd360) : 9'(w_tsum);
        if (w_tdeg <= 9'd90) begin
            w_tk = 7'(w_tdeg);               w_tneg = 1'b0;
        end else if (w_tdeg <= 9'd180) begin
            w_tk = 7'(9'd180 - w_tdeg);      w_tneg = 1'b0;
        end else if (w_tdeg <= 9'd270) begin
            w_tk = 7'(w_tdeg - 9'd180);      w_tneg = 1'b1;
        end else begin
            w_tk = 7'(9'd360 - w_tdeg);      w_tneg = 1'b1;
        end
        w_tmag = TW'(SINE_TAB[w_tk][SINE_BITS:0]);
        w_tval = w_tneg ? -w_tmag : w_tmag;
    end

    // micro-op pipe
    afk_pkg::t_uop w_u0;
    afk_pkg::t_uop r_u1, r_u2;
    logic          r_v1, r_v2;
    logic [TW-1:0] w_rdata_a, w_rdata_b;

    assign w_u0 = afk_pkg::f_uop(i_cmd.uop_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u1 <= w_u0;
        r_u2 <= r_u1;
    end

    // stage 1: operand select and multiply
    logic [afk_pkg::LEN_W-1:0] w_len;
    logic signed [OW-1:0]      w_aop, w_bop;
    logic signed [PW-1:0]      r_prod;

    always_comb begin
        unique case (r_u1.len_sel)
            afk_pkg::LEN_H:  w_len = r_base_height;
            afk_pkg::LEN_L1: w_len = r_first_link;
            afk_pkg::LEN_L2: w_len = r_second_link;
            default:         w_len = '0;
        endcase
        w_aop = r_u1.a_len ? signed'(OW'(w_len)) : OW'($signed(w_rdata_a));
        w_bop = r_u1.b_one ? (OW'(1) <<< SINE_BITS) : OW'($signed(w_rdata_b));
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(w_aop) * PW'(w_bop);
    end

    // stage 2: round half away from zero, or exact accumulate
    logic [PW-1:0]        w_pmag, w_prnd;
    logic signed [PW-1:0] w_prs;
    logic [TW-1:0]        w_rt, w_rsg, w_wbval;
    logic [TW-1:0]        r_prev;
    logic                 w_wb_t;
    logic                 w_wb_acc;
    logic signed [AW-1:0] w_pext;
    logic signed [AW-1:0] r_acc [3];

    always_comb begin
        w_pmag  = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);
        w_prnd  = (w_pmag + (PW'(1) << (SINE_BITS - 1))) >> SINE_BITS;
        w_prs   = r_prod[PW-1] ? -signed'(w_prnd) : signed'(w_prnd);
        w_rt    = w_prs[TW-1:0];
        w_rsg   = r_u2.sgn ? -w_rt : w_rt;
        w_wbval = ((r_u2.kind == afk_pkg::K_RNDADD) ? r_prev : '0) + w_rsg;
        w_wb_t  = r_v2 && (r_u2.kind == afk_pkg::K_RND || r_u2.kind == afk_pkg::K_RNDADD);
        w_wb_acc = r_v2 && (r_u2.kind == afk_pkg::K_ACC) && (r_mode == afk_pkg::MODE_QUERY)
                   && (r_idx >= r_u2.level) && (r_idx <= afk_pkg::SERVO5);
        w_pext  = AW'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (w_wb_t) begin
            r_prev <= w_wbval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            for (int j = 0; j < 3; j++) begin
                r_acc[j] <= '0;
            end
        end else if (w_wb_acc) begin
            r_acc[r_u2.dst[1:0]] <= r_acc[r_u2.dst[1:0]] + (r_u2.sgn ? -w_pext : w_pext);
        end
    end

    // scratch file for trig values and products
    afk_ram #(
        .WIDTH (TW),
        .DEPTH (afk_pkg::NUM_TREGS)
    ) u_tram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.trig_en || w_wb_t),
        .i_waddr   (i_cmd.trig_en ? TA'({w_tcos, w_tj}) : r_u2.dst),
        .i_wdata   (i_cmd.trig_en ? w_tval : w_wbval),
        .i_raddr_a (w_u0.a_idx),
        .i_raddr_b (w_u0.b_idx),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // final scale: drop SINE_BITS with rounding, then saturate
    function automatic logic signed [PWN-1:0] f_finish(input logic signed [AW-1:0] v);
        logic [AW-1:0]        m;
        logic [AW-1:0]        r;
        logic signed [AW-1:0] s;
        m = v[AW-1] ? AW'(-v) : AW'(v);
        r = (m + (AW'(1) << (SINE_BITS - 1))) >> SINE_BITS;
        s = v[AW-1] ? -signed'(r) : signed'(r);
        if (s > SAT_HI) begin
            s = SAT_HI;
        end else if (s < SAT_LO) begin
            s = SAT_LO;
        end
        return s[PWN-1:0];
    endfunction

    logic signed [PWN-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic signed [AWG-1:0] r_echo_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pos_x    <= f_finish(r_acc[afk_pkg::ACC_X]);
            r_pos_y    <= f_finish(r_acc[afk_pkg::ACC_Y]);
            r_pos_z    <= f_finish(r_acc[afk_pkg::ACC_Z]);
            r_echo_out <= r_echo;
        end
    end

    assign o_pos_x      = r_pos_x;
    assign o_pos_y      = r_pos_y;
    assign o_pos_z      = r_pos_z;
    assign o_echo_angle = r_echo_out;

endmodule
`default_nettype wire
